@@ rtl/pcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types, codes and helpers for the palette color search block.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int MetricW = 18;
    localparam logic [MetricW-1:0] NearStart = '1;
    localparam logic [MetricW-1:0] DarkStart = 18'd258;

    typedef enum logic [2:0] {
        REQ_WRITE   = 3'd0,
        REQ_NEAREST = 3'd1,
        REQ_EXACT   = 3'd2,
        REQ_BRIGHT  = 3'd3,
        REQ_DARK    = 3'd4
    } t_req;

    // query word that walks the chain together with the running best
    typedef struct packed {
        logic               active;
        t_req               req;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               incl;
        logic               skip;
        logic               found;
        logic               hit;
        logic [MetricW-1:0] metric;
    } t_token;

    // floor((30r + 59g + 11b) / 100), the division by a reciprocal multiply
    function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        logic [14:0] sum;
        logic [27:0] prod;
        sum  = 15'(30 * r) + 15'(59 * g) + 15'(11 * b);
        prod = 28'(sum) * 28'd5243;
        return prod[26:19];
    endfunction

endpackage

@@ rtl/pcs_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_cell
// One palette entry plus one compare step of the query chain.
// ----------------------------------------------------------------------------
module pcs_cell
    import pcs_pkg::*;
#(
    parameter int CELL_ID = 0,
    parameter int IW      = 8,
    parameter int CW      = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [23:0]   i_wr_color,
    input  logic          i_wr_used,
    input  logic [7:0]    i_wr_gray,
    input  logic [CW-1:0] i_limit,
    input  t_token        i_tok,
    input  logic [IW-1:0] i_idx,
    output t_token        o_tok,
    output logic [IW-1:0] o_idx
);

    logic [23:0]   r_color;
    logic          r_used;
    logic [7:0]    r_gray;
    t_token        r_tok;
    logic [IW-1:0] r_idx;
    t_token        n_tok;
    logic [IW-1:0] n_idx;

    logic               en;
    logic               cand;
    logic signed [8:0]  dr, dg, db;
    logic signed [17:0] pr, pg, pb;
    logic [MetricW-1:0] sq_dist;
    logic [MetricW-1:0] gray_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= '0;
            r_used  <= 1'b0;
            r_gray  <= '0;
        end else if (i_wr_en) begin
            r_color <= i_wr_color;
            r_used  <= i_wr_used;
            r_gray  <= i_wr_gray;
        end
    end

    always_comb begin
        en      = (CW'(CELL_ID) < i_limit);
        cand    = en && (i_tok.incl || r_used);
        dr      = $signed({1'b0, i_tok.red})   - $signed({1'b0, r_color[23:16]});
        dg      = $signed({1'b0, i_tok.green}) - $signed({1'b0, r_color[15:8]});
        db      = $signed({1'b0, i_tok.blue})  - $signed({1'b0, r_color[7:0]});
        pr      = dr * dr;
        pg      = dg * dg;
        pb      = db * db;
        sq_dist = MetricW'(pr[15:0]) + MetricW'(pg[15:0]) + MetricW'(pb[15:0]);
        gray_w  = MetricW'(r_gray);
        n_tok   = i_tok;
        n_idx   = i_idx;
        case (i_tok.req)
            REQ_NEAREST: begin
                if (en && sq_dist < i_tok.metric) begin
                    n_tok.metric = sq_dist;
                    n_tok.hit    = 1'b1;
                    n_idx        = IW'(CELL_ID);
                end
            end
            REQ_EXACT: begin
                if (en && r_used && !i_tok.found &&
                    r_color == {i_tok.red, i_tok.green, i_tok.blue}) begin
                    n_tok.found = 1'b1;
                    n_idx       = IW'(CELL_ID);
                end
            end
            REQ_BRIGHT: begin
                if (cand && gray_w > i_tok.metric) begin
                    n_tok.metric = gray_w;
                    n_idx        = IW'(CELL_ID);
                end
            end
            REQ_DARK: begin
                if (cand && gray_w < i_tok.metric && (r_gray != 8'd0 || !i_tok.skip)) begin
                    n_tok.metric = gray_w;
                    n_tok.hit    = 1'b1;
                    n_idx        = IW'(CELL_ID);
                end
            end
            default: begin
                n_tok = i_tok;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.active <= 1'b0;
        end else begin
            r_tok.active <= i_tok.active;
        end
        r_tok.req    <= n_tok.req;
        r_tok.red    <= n_tok.red;
        r_tok.green  <= n_tok.green;
        r_tok.blue   <= n_tok.blue;
        r_tok.incl   <= n_tok.incl;
        r_tok.skip   <= n_tok.skip;
        r_tok.found  <= n_tok.found;
        r_tok.hit    <= n_tok.hit;
        r_tok.metric <= n_tok.metric;
        r_idx        <= n_idx;
    end

    assign o_tok = r_tok;
    assign o_idx = r_idx;

endmodule

@@ rtl/palette_color_search_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_color_search_top
// Palette of RGB entries held in a row of cells; queries walk the row.
// ----------------------------------------------------------------------------
// channel   direction  handshake                        payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tuser req, tdata entry fields
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata result fields
// cfg       in         i_cfg_wr_en                      i_cfg_wr_data entry_count
//
// a write item stores straight into its cell
// a query item passes one cell per cycle: registered in the head, in each cell
// in turn, then in the output register; one query in flight at a time
// reset clears every entry at once, no clearing pass
// a waiting result holds in the output register; a new query is taken only
// when that register is free or being emptied
// ----------------------------------------------------------------------------
module palette_color_search_top
    import pcs_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // entry_index, red_in, green_in, blue_in, used_in, include_unused, skip_black
    input  logic [39:0] i_s_axis_tdata,
    // req_type
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // result_index, match_found, best_metric
    output logic [31:0] o_m_axis_tdata
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = (CW > 9) ? CW : 9;

    logic [8:0]    r_entry_count;
    logic          r_busy;
    t_token        r_head;
    logic          r_out_valid;
    logic [31:0]   r_out;
    logic [CW-1:0] limit;
    logic          accept;
    t_req          req;
    logic          is_query;
    logic          wr;
    logic [7:0]    wr_gray;
    logic [31:0]   n_out;
    logic [7:0]    o_idx8;
    logic          o_found;
    logic [MetricW-1:0] o_metric;

    t_token        tok [MAX_ENTRIES+1];
    logic [IW-1:0] idx [MAX_ENTRIES+1];

    assign req      = t_req'(i_s_axis_tuser);
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign is_query = (req == REQ_NEAREST) || (req == REQ_EXACT) ||
                      (req == REQ_BRIGHT) || (req == REQ_DARK);
    assign wr       = accept && (req == REQ_WRITE) &&
                      (32'(i_s_axis_tdata[7:0]) < MAX_ENTRIES);
    assign wr_gray  = gray_of(i_s_axis_tdata[15:8], i_s_axis_tdata[23:16],
                              i_s_axis_tdata[31:24]);
    assign limit    = (LW'(r_entry_count) > LW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                              : CW'(r_entry_count);

    assign o_s_axis_tready = !r_busy && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= 9'd256;
        end else if (i_cfg_wr_en) begin
            r_entry_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.active <= 1'b0;
            r_busy        <= 1'b0;
        end else begin
            r_head.active <= accept && is_query;
            if (accept && is_query) begin
                r_busy <= 1'b1;
            end else if (tok[MAX_ENTRIES].active) begin
                r_busy <= 1'b0;
            end
        end
        r_head.req    <= req;
        r_head.red    <= i_s_axis_tdata[15:8];
        r_head.green  <= i_s_axis_tdata[23:16];
        r_head.blue   <= i_s_axis_tdata[31:24];
        r_head.incl   <= i_s_axis_tdata[33];
        r_head.skip   <= i_s_axis_tdata[34];
        r_head.found  <= 1'b0;
        r_head.hit    <= 1'b0;
        r_head.metric <= (req == REQ_NEAREST) ? NearStart :
                         (req == REQ_DARK)    ? DarkStart : '0;
    end

    assign tok[0] = r_head;
    assign idx[0] = '0;

    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        pcs_cell #(
            .CELL_ID (k),
            .IW      (IW),
            .CW      (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (wr && (32'(i_s_axis_tdata[7:0]) == k)),
            // stored as red, green, blue from the top bits down
            .i_wr_color ({i_s_axis_tdata[15:8], i_s_axis_tdata[23:16],
                          i_s_axis_tdata[31:24]}),
            .i_wr_used  (i_s_axis_tdata[32]),
            .i_wr_gray  (wr_gray),
            .i_limit    (limit),
            .i_tok      (tok[k]),
            .i_idx      (idx[k]),
            .o_tok      (tok[k+1]),
            .o_idx      (idx[k+1])
        );
    end

    always_comb begin
        o_idx8   = 8'(idx[MAX_ENTRIES]);
        o_found  = 1'b1;
        o_metric = tok[MAX_ENTRIES].metric;
        case (tok[MAX_ENTRIES].req) inside
            REQ_NEAREST, REQ_DARK: begin
                if (!tok[MAX_ENTRIES].hit) begin
                    o_metric = '0;
                end
            end
            REQ_EXACT: begin
                o_found  = tok[MAX_ENTRIES].found;
                o_metric = '0;
            end
            default: begin
                o_metric = tok[MAX_ENTRIES].metric;
            end
        endcase
        n_out = {5'd0, o_metric, o_found, o_idx8};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tok[MAX_ENTRIES].active) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (tok[MAX_ENTRIES].active) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

`ifndef SYNTH
    // a query leaving the chain never lands on an undelivered result
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[MAX_ENTRIES].active |-> (!r_out_valid || i_m_axis_tready))
        else $error("result register overwritten");

    // busy drops only when the query reaches the end of the chain
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(tok[MAX_ENTRIES].active))
        else $error("busy cleared early");

    // an exact miss reports index zero and metric zero
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[8]) |-> (o_m_axis_tdata[31:0] == 32'd0))
        else $error("exact miss with nonzero payload");

    // no query enters while one is in the chain
    a_one_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head.active |-> !$past(r_busy))
        else $error("second query entered chain");
`endif

endmodule

@@ verif/tb_palette_color_search_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_color_search_top
// Self-checking bench for the palette color search block. Palette writes and
// queries are driven on the input stream. A behavioral palette in the bench
// predicts query answers, and output items are compared in order. A
// directed table runs first, then random traffic under several scan lengths,
// with random idling on both streams, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module tb_palette_color_search_top;
    import pcs_pkg::*;

    localparam int Entries  = 256;
    localparam int Settle   = Entries + 20;
    localparam int Watchdog = 5000;

    typedef struct packed {
        logic [7:0]  idx;
        logic        found;
        logic [17:0] metric;
    } t_answer;

    typedef struct {
        logic [2:0] req;
        logic [7:0] idx;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        bit         used;
        bit         incl;
        bit         skip;
        bit         typed;
        t_answer    ans;
    } t_stim;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [8:0]  i_cfg_wr_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // entry_index, red_in, green_in, blue_in, used_in, include_unused, skip_black
    logic [39:0] i_s_axis_tdata;
    // req_type
    logic [2:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // result_index, match_found, best_metric
    logic [31:0] o_m_axis_tdata;

    palette_color_search_top #(.MAX_ENTRIES(Entries)) u_top (.*);

    // bench copy of the palette
    logic [23:0] pal_color [Entries];
    bit          pal_used  [Entries];
    int          scan_len;

    t_answer pending_answers[$];
    int      mismatches;
    bit      idle_off;
    bit      hold_go;
    int      stall_cycles;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int gray(logic [23:0] c);
        return (30 * c[23:16] + 59 * c[15:8] + 11 * c[7:0]) / 100;
    endfunction

    function automatic int sqd(logic [7:0] a, logic [7:0] b);
        int d;
        d = int'(a) - int'(b);
        return d * d;
    endfunction

    function automatic t_answer palette_search(t_stim s);
        t_answer a;
        int n;
        int best;
        int nd;
        int gr;
        n = (scan_len > Entries) ? Entries : scan_len;
        a = '{idx: 8'd0, found: 1'b1, metric: 18'd0};
        case (s.req)
            REQ_NEAREST: begin
                best = 'h100000;
                for (int i = 0; i < n; i++) begin
                    nd = sqd(s.r, pal_color[i][23:16]) + sqd(s.g, pal_color[i][15:8])
                       + sqd(s.b, pal_color[i][7:0]);
                    if (nd < best) begin
                        best = nd;
                        a.idx = i[7:0];
                    end
                end
                a.metric = (n == 0) ? 18'd0 : best[17:0];
            end
            REQ_EXACT: begin
                a.found = 1'b0;
                for (int i = 0; i < n; i++) begin
                    if (!a.found && pal_used[i] && pal_color[i] == {s.r, s.g, s.b}) begin
                        a.found = 1'b1;
                        a.idx = i[7:0];
                    end
                end
            end
            REQ_BRIGHT: begin
                best = 0;
                for (int i = 0; i < n; i++) begin
                    gr = gray(pal_color[i]);
                    if ((s.incl || pal_used[i]) && gr > best) begin
                        best = gr;
                        a.idx = i[7:0];
                    end
                end
                a.metric = best[17:0];
            end
            default: begin
                best = 258;
                for (int i = 0; i < n; i++) begin
                    gr = gray(pal_color[i]);
                    if ((s.incl || pal_used[i]) && gr < best && (gr != 0 || !s.skip)) begin
                        best = gr;
                        a.idx = i[7:0];
                    end
                end
                a.metric = (best == 258) ? 18'd0 : best[17:0];
            end
        endcase
        return a;
    endfunction

    // palette update or answer prediction at the accepting edge
    function automatic void take_item(t_stim s);
        if (s.req == REQ_WRITE) begin
            pal_color[s.idx] = {s.r, s.g, s.b};
            pal_used[s.idx]  = s.used;
        end else if (s.req == REQ_NEAREST || s.req == REQ_EXACT || s.req == REQ_BRIGHT
                     || s.req == REQ_DARK) begin
            pending_answers.push_back(s.typed ? s.ans : palette_search(s));
        end
    endfunction

    task automatic send_item(t_stim s);
        while (!idle_off && $urandom_range(99) < 22) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= s.req;
        i_s_axis_tdata  <= {5'd0, s.skip, s.incl, s.used, s.b, s.g, s.r, s.idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        take_item(s);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (Settle) @(posedge i_clk);
    endtask

    task automatic write_scan_len(logic [8:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        scan_len = v;
    endtask

    function automatic t_stim random_item();
        t_stim s;
        int k;
        int pick;
        s.typed = 1'b0;
        s.ans   = '0;
        pick    = $urandom_range(99);
        s.idx   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
        s.r = 8'($urandom);
        s.g = 8'($urandom);
        s.b = 8'($urandom);
        if ($urandom_range(5) == 0) begin
            s.r = {8{s.r[0]}};
            s.g = {8{s.g[0]}};
            s.b = {8{s.b[0]}};
        end
        s.used = 1'($urandom);
        s.incl = 1'($urandom);
        s.skip = 1'($urandom);
        if (pick < 55) begin
            s.req = REQ_WRITE;
        end else if (pick < 97) begin
            s.req = 3'($urandom_range(REQ_NEAREST, REQ_DARK));
            // aim exact queries mostly at stored colors
            if (s.req == REQ_EXACT && $urandom_range(3) != 0) begin
                k = $urandom_range(15);
                {s.r, s.g, s.b} = pal_color[k];
            end
        end else begin
            s.req = 3'($urandom_range(5, 7));
        end
        return s;
    endfunction

    function automatic t_stim row(logic [2:0] req, logic [7:0] idx, logic [7:0] r,
                                  logic [7:0] g, logic [7:0] b, bit used, bit incl,
                                  bit skip, bit typed, t_answer ans);
        t_stim s;
        s = '{req, idx, r, g, b, used, incl, skip, typed, ans};
        return s;
    endfunction

    // output stream ready, with random gaps and a long hold on request
    always @(posedge i_clk) begin
        if (hold_go) begin
            stall_cycles <= stall_cycles + 1;
            i_m_axis_tready <= 1'b0;
            if (stall_cycles == 700) begin
                hold_go <= 1'b0;
            end
        end else begin
            stall_cycles <= 0;
            i_m_axis_tready <= idle_off || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.idx    = o_m_axis_tdata[7:0];
            got.found  = o_m_axis_tdata[8];
            got.metric = o_m_axis_tdata[26:9];
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item idx=%0d found=%0d metric=%0d",
                             got.idx, got.found, got.metric);
                end
            end else begin
                want = pending_answers.pop_front();
                if (got !== want || o_m_axis_tdata[31:27] !== 5'd0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp idx/found/metric %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.idx, want.found, want.metric,
                                 got.idx, got.found, got.metric);
                    end
                end
            end
        end
    end

    int quiet_cycles;
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= Watchdog) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        t_stim dir[$];
        logic [8:0] phases[7];
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        i_m_axis_tready <= 1'b0;
        idle_off     = 1'b0;
        hold_go      = 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        scan_len     = 256;
        for (int i = 0; i < Entries; i++) begin
            pal_color[i] = '0;
            pal_used[i]  = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cleared palette: answers known without a search
        dir.push_back(row(REQ_NEAREST, 0, 255, 255, 255, 0, 0, 0, 1, '{0, 1, 195075}));
        dir.push_back(row(REQ_EXACT,   0, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0}));
        dir.push_back(row(REQ_BRIGHT,  0, 0, 0, 0, 0, 1, 0, 1, '{0, 1, 0}));
        dir.push_back(row(REQ_DARK,    0, 0, 0, 0, 0, 1, 0, 1, '{0, 1, 0}));
        dir.push_back(row(REQ_DARK,    0, 0, 0, 0, 0, 1, 1, 1, '{0, 1, 0}));
        dir.push_back(row(REQ_WRITE, 255, 255, 255, 255, 1, 1, 1, 0, '0));
        dir.push_back(row(REQ_WRITE,   0, 0, 0, 0, 1, 0, 0, 0, '0));
        dir.push_back(row(REQ_WRITE,   1, 255, 0, 0, 0, 0, 0, 0, '0));
        dir.push_back(row(REQ_WRITE,   2, 0, 0, 255, 1, 0, 0, 0, '0));
        // same color again: earlier entry must win ties
        dir.push_back(row(REQ_WRITE,   3, 0, 0, 255, 1, 0, 0, 0, '0));
        // unknown request codes give nothing
        dir.push_back(row(3'd5, 255, 255, 255, 255, 1, 1, 1, 0, '0));
        dir.push_back(row(3'd6, 0, 0, 0, 0, 0, 0, 0, 0, '0));
        dir.push_back(row(3'd7, 255, 255, 255, 255, 1, 1, 1, 0, '0));
        dir.push_back(row(REQ_NEAREST, 0, 0, 0, 0, 0, 0, 0, 0, '0));
        dir.push_back(row(REQ_NEAREST, 0, 255, 255, 255, 0, 0, 0, 0, '0));
        dir.push_back(row(REQ_NEAREST, 0, 10, 0, 250, 0, 0, 0, 0, '0));
        dir.push_back(row(REQ_EXACT,   0, 0, 0, 255, 0, 0, 0, 0, '0));
        dir.push_back(row(REQ_EXACT,   0, 255, 0, 0, 0, 0, 0, 0, '0));
        dir.push_back(row(REQ_BRIGHT,  0, 0, 0, 0, 0, 0, 0, 0, '0));
        dir.push_back(row(REQ_BRIGHT,  0, 0, 0, 0, 0, 1, 0, 0, '0));
        dir.push_back(row(REQ_DARK,    0, 0, 0, 0, 0, 0, 0, 0, '0));
        dir.push_back(row(REQ_DARK,    0, 0, 0, 0, 0, 0, 1, 0, '0));
        dir.push_back(row(REQ_DARK,    0, 0, 0, 0, 0, 1, 1, 0, '0));
        foreach (dir[i]) send_item(dir[i]);

        phases = '{9'd1, 9'd255, 9'd0, 9'd511, 9'd256, 9'd2, 9'($urandom_range(3, 510))};
        foreach (phases[p]) begin
            wait_drained();
            write_scan_len(phases[p]);
            idle_off = (p == 3);
            for (int n = 0; n < 110; n++) begin
                if (p == 1 && n == 20) hold_go = 1'b1;
                if (p == 2 && n == 50) begin
                    i_s_axis_tvalid <= 1'b0;
                    wait (pending_answers.size() == 0);
                end
                send_item(random_item());
            end
        end
        i_s_axis_tvalid <= 1'b0;
        idle_off = 1'b0;

        wait (pending_answers.size() == 0);
        repeat (Settle) @(posedge i_clk);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
